[hdl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BLIR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that is checked during reset too.
`define BLIR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

[hdl/blir_pkg.sv]
// ---------------------------------------------------------------------------
// blir_pkg
// Types, codes and sizes shared by the bounded list blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package blir_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int COUNT_W    = 9;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [63:0]           t_wide;
    typedef logic [COUNT_W-1:0]    t_count;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPEND,
        OP_INSERT,
        OP_REMOVE,
        OP_READ
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    load_result;
        t_op     op;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action action;
        logic    pos_live;
        logic    full;
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/blir_if.sv]
// ---------------------------------------------------------------------------
// blir_req_if / blir_rsp_if
// Valid/ready channels for list requests and list responses.
// ---------------------------------------------------------------------------
`default_nettype none

interface blir_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [31:0]       item_value;
    logic signed [9:0] position;

    modport source (output valid, output action, output item_value, output position,
                    input ready);
    modport sink   (input valid, input action, input item_value, input position,
                    output ready);
endinterface

interface blir_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [8:0]  entry_count;

    modport source (output valid, output status, output read_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    output ready);
endinterface

`default_nettype wire

[hdl/blir_datapath.sv]
// ---------------------------------------------------------------------------
// blir_datapath
// Request registers, the chain of list cells, the live count and the
// response registers.
// ---------------------------------------------------------------------------
`default_nettype none

module blir_datapath (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire blir_pkg::t_dp_cmd i_cmd,
    output blir_pkg::t_dp_stat     o_stat,
    input  wire [1:0]              i_action,
    input  wire [31:0]             i_item_value,
    input  wire signed [9:0]       i_position,
    output logic [1:0]             o_status,
    output logic [31:0]            o_read_value,
    output logic [8:0]             o_entry_count
);

    logic [1:0]        r_action;
    blir_pkg::t_word   r_value;
    logic signed [9:0] r_position;
    blir_pkg::t_count  r_count;
    blir_pkg::t_count  n_count;

    blir_pkg::t_word   r_cell [blir_pkg::CAPACITY];
    blir_pkg::t_word   n_cell [blir_pkg::CAPACITY];
    blir_pkg::t_word   w_left [blir_pkg::CAPACITY];
    blir_pkg::t_word   w_right[blir_pkg::CAPACITY];

    blir_pkg::t_status r_status;
    logic [31:0]       r_read_value;
    blir_pkg::t_count  r_rsp_count;

    blir_pkg::t_count  w_pos;
    blir_pkg::t_word   w_rd_word;
    blir_pkg::t_wide   w_rd_wide;

    // Positions are only used once they are known to be non-negative.
    assign w_pos = r_position[8:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= i_action;
            r_value    <= blir_pkg::t_word'(i_item_value);
            r_position <= i_position;
        end
    end

    assign o_stat.action   = blir_pkg::t_action'(r_action);
    assign o_stat.pos_live = !r_position[9] && (w_pos < r_count);
    assign o_stat.full     = (r_count == blir_pkg::t_count'(blir_pkg::CAPACITY));

    // Each cell picks its next value from itself, the new value or one of
    // its two neighbors, so all cells shift together in one register update.
    for (genvar g = 0; g < blir_pkg::CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = r_cell[g];
        end else begin : g_left
            assign w_left[g] = r_cell[g-1];
        end
        if (g == blir_pkg::CAPACITY - 1) begin : g_last
            assign w_right[g] = r_cell[g];
        end else begin : g_right
            assign w_right[g] = r_cell[g+1];
        end

        always_comb begin
            n_cell[g] = r_cell[g];
            unique case (i_cmd.op)
                blir_pkg::OP_APPEND: begin
                    if (blir_pkg::t_count'(g) == r_count) n_cell[g] = r_value;
                end
                blir_pkg::OP_INSERT: begin
                    if (blir_pkg::t_count'(g) == w_pos) begin
                        n_cell[g] = r_value;
                    end else if (blir_pkg::t_count'(g) > w_pos &&
                                 blir_pkg::t_count'(g) <= r_count) begin
                        n_cell[g] = w_left[g];
                    end
                end
                blir_pkg::OP_REMOVE: begin
                    if (blir_pkg::t_count'(g) >= w_pos &&
                        blir_pkg::t_count'(g) + 9'd1 < r_count) begin
                        n_cell[g] = w_right[g];
                    end
                end
                default: begin
                    n_cell[g] = r_cell[g];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_comb begin
        n_count = r_count;
        unique case (i_cmd.op)
            blir_pkg::OP_APPEND, blir_pkg::OP_INSERT: n_count = r_count + 9'd1;
            blir_pkg::OP_REMOVE:                      n_count = r_count - 9'd1;
            default:                                  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign w_rd_word = r_cell[r_position[blir_pkg::IDX_W-1:0]];
    assign w_rd_wide = blir_pkg::t_wide'(w_rd_word);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_status     <= i_cmd.status;
            r_read_value <= (i_cmd.op == blir_pkg::OP_READ) ? w_rd_wide[31:0] : 32'd0;
            r_rsp_count  <= n_count;
        end
    end

    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_entry_count = r_rsp_count;

endmodule

`default_nettype wire

[hdl/blir_ctrl.sv]
// ---------------------------------------------------------------------------
// blir_ctrl
// Controller: request and response handshakes, and the decision of which
// list operation runs and which status it reports.
// ---------------------------------------------------------------------------
`default_nettype none

module blir_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_req_valid,
    output logic                    o_req_ready,
    output logic                    o_rsp_valid,
    input  wire                     i_rsp_ready,
    input  wire blir_pkg::t_dp_stat i_stat,
    output blir_pkg::t_dp_cmd       o_cmd
);

    blir_pkg::t_state r_state;
    blir_pkg::t_state n_state;
    logic             r_rsp_valid;
    logic             n_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blir_pkg::S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_rsp_valid       = r_rsp_valid && !i_rsp_ready;
        o_req_ready       = 1'b0;
        o_cmd.capture     = 1'b0;
        o_cmd.load_result = 1'b0;
        o_cmd.op          = blir_pkg::OP_NONE;
        o_cmd.status      = blir_pkg::ST_OK;
        unique case (r_state)
            blir_pkg::S_IDLE: begin
                // A new request is taken once the response slot is free or
                // is being emptied in this cycle.
                o_req_ready   = !r_rsp_valid || i_rsp_ready;
                o_cmd.capture = i_req_valid && o_req_ready;
                if (o_cmd.capture) n_state = blir_pkg::S_EXEC;
            end
            blir_pkg::S_EXEC: begin
                o_cmd.load_result = 1'b1;
                n_rsp_valid       = 1'b1;
                n_state           = blir_pkg::S_IDLE;
                unique case (i_stat.action)
                    blir_pkg::ACT_APPEND: begin
                        if (i_stat.full) o_cmd.status = blir_pkg::ST_FULL;
                        else             o_cmd.op     = blir_pkg::OP_APPEND;
                    end
                    blir_pkg::ACT_INSERT: begin
                        // The index check takes precedence over the full check.
                        priority if (!i_stat.pos_live) o_cmd.status = blir_pkg::ST_BAD_INDEX;
                        else if (i_stat.full)          o_cmd.status = blir_pkg::ST_FULL;
                        else                           o_cmd.op     = blir_pkg::OP_INSERT;
                    end
                    blir_pkg::ACT_REMOVE: begin
                        if (!i_stat.pos_live) o_cmd.status = blir_pkg::ST_BAD_INDEX;
                        else                  o_cmd.op     = blir_pkg::OP_REMOVE;
                    end
                    blir_pkg::ACT_READ: begin
                        if (!i_stat.pos_live) o_cmd.status = blir_pkg::ST_BAD_INDEX;
                        else                  o_cmd.op     = blir_pkg::OP_READ;
                    end
                endcase
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

[hdl/bounded_list_insert_remove.sv]
// ---------------------------------------------------------------------------
// bounded_list_insert_remove
// Fixed-capacity ordered list with append, insert, remove and read.
// ---------------------------------------------------------------------------
// Each request passes through the two controller states: S_IDLE registers
// it, and in S_EXEC every list cell loads its new value in parallel and
// the response is written, so a new request is taken only once the last
// one is through. A response waiting on a stalled sink holds off the next
// request. Every request returns one response with the status, the read
// value and the entry count after it.
`default_nettype none

module bounded_list_insert_remove (
    input  wire        i_clk,
    input  wire        i_rst_n,
    blir_req_if.sink   i_req,
    blir_rsp_if.source o_rsp
);

    blir_pkg::t_dp_cmd  w_cmd;
    blir_pkg::t_dp_stat w_stat;

    blir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    blir_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_req.action),
        .i_item_value  (i_req.item_value),
        .i_position    (i_req.position),
        .o_status      (o_rsp.status),
        .o_read_value  (o_rsp.read_value),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

`default_nettype wire

[hdl/blir_checker.sv]
// ---------------------------------------------------------------------------
// blir_checker
// Port-level checks on the bounded list, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module blir_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_req_valid,
    input wire        i_req_ready,
    input wire        i_rsp_valid,
    input wire        i_rsp_ready,
    input wire [1:0]  i_status,
    input wire [31:0] i_read_value,
    input wire [8:0]  i_entry_count
);

    logic w_req_acc;
    logic w_rsp_stall;

    assign w_req_acc   = i_req_valid && i_req_ready;
    assign w_rsp_stall = i_rsp_valid && !i_rsp_ready;

    // Every accepted request shows its response once the S_EXEC state has loaded it.
    `BLIR_ASSERT(a_rsp_follows_req, i_clk, i_rst_n, w_req_acc |-> ##2 i_rsp_valid)

    // A failed operation never returns data.
    `BLIR_ASSERT(a_fail_zero_data, i_clk, i_rst_n, (i_rsp_valid && i_status != blir_pkg::ST_OK) |-> (i_read_value == 32'd0))

    // The reported count never passes the capacity.
    `BLIR_ASSERT(a_count_bound, i_clk, i_rst_n, i_rsp_valid |-> (i_entry_count <= blir_pkg::CAPACITY))

    // A stalled response keeps its payload.
    `BLIR_ASSERT(a_rsp_hold, i_clk, i_rst_n, w_rsp_stall |=> (i_rsp_valid && $stable(i_status) && $stable(i_read_value) && $stable(i_entry_count)))

    // No response is pending right after reset.
    `BLIR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_rsp_valid)

endmodule

bind bounded_list_insert_remove blir_checker u_blir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_read_value  (o_rsp.read_value),
    .i_entry_count (o_rsp.entry_count)
);

`default_nettype wire

[bench/tb_bounded_list_insert_remove.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_bounded_list_insert_remove
// Drives list requests through the request channel and checks every response
// against a shadow copy of the list kept in the bench. A directed table covers
// the empty and full list, bad positions and the field extremes. Biased
// random traffic then grows and shrinks the list many times. Both channels
// see random gaps and stalls, with one stretch of back-to-back transactions.
// ---------------------------------------------------------------------------

module tb_bounded_list_insert_remove;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 900;
    localparam int N_ROWS       = 18;

    typedef struct packed {
        blir_pkg::t_status status;
        blir_pkg::t_word   read_value;
        blir_pkg::t_count  entry_count;
    } t_list_rsp;

    typedef struct packed {
        blir_pkg::t_action action;
        blir_pkg::t_word   value;
        logic [9:0]        position;
        logic [4:0]        repeats;
        logic              typed;
        t_list_rsp         rsp;
    } t_step_row;

    // Rows with typed set carry their response; the others use the shadow list.
    localparam t_step_row STEPS [N_ROWS] = '{
        '{blir_pkg::ACT_READ,   32'h0000_0000, 10'h000, 5'd1,  1'b1,
          '{blir_pkg::ST_BAD_INDEX, 32'h0, 9'd0}},
        '{blir_pkg::ACT_INSERT, 32'hDEAD_BEEF, 10'h000, 5'd1,  1'b1,
          '{blir_pkg::ST_BAD_INDEX, 32'h0, 9'd0}},
        '{blir_pkg::ACT_REMOVE, 32'h0000_0000, 10'h3FF, 5'd1,  1'b1,
          '{blir_pkg::ST_BAD_INDEX, 32'h0, 9'd0}},
        '{blir_pkg::ACT_APPEND, 32'hFFFF_FFFF, 10'h000, 5'd1,  1'b1,
          '{blir_pkg::ST_OK, 32'h0, 9'd1}},
        '{blir_pkg::ACT_READ,   32'h0000_0000, 10'h000, 5'd1,  1'b1,
          '{blir_pkg::ST_OK, 32'hFFFF_FFFF, 9'd1}},
        '{blir_pkg::ACT_APPEND, 32'h1234_5678, 10'h000, 5'd14, 1'b0,
          '{blir_pkg::ST_OK, 32'h0, 9'd0}},
        '{blir_pkg::ACT_APPEND, 32'h0000_0000, 10'h000, 5'd1,  1'b1,
          '{blir_pkg::ST_OK, 32'h0, 9'd16}},
        '{blir_pkg::ACT_APPEND, 32'h5555_5555, 10'h000, 5'd1,  1'b1,
          '{blir_pkg::ST_FULL, 32'h0, 9'd16}},
        '{blir_pkg::ACT_INSERT, 32'hAAAA_AAAA, 10'h005, 5'd1,  1'b1,
          '{blir_pkg::ST_FULL, 32'h0, 9'd16}},
        '{blir_pkg::ACT_INSERT, 32'hAAAA_AAAA, 10'h010, 5'd1,  1'b1,
          '{blir_pkg::ST_BAD_INDEX, 32'h0, 9'd16}},
        '{blir_pkg::ACT_READ,   32'h0000_0000, 10'h00F, 5'd1,  1'b1,
          '{blir_pkg::ST_OK, 32'h0, 9'd16}},
        '{blir_pkg::ACT_READ,   32'h0000_0000, 10'h1FF, 5'd1,  1'b1,
          '{blir_pkg::ST_BAD_INDEX, 32'h0, 9'd16}},
        '{blir_pkg::ACT_REMOVE, 32'h0000_0000, 10'h200, 5'd1,  1'b1,
          '{blir_pkg::ST_BAD_INDEX, 32'h0, 9'd16}},
        '{blir_pkg::ACT_REMOVE, 32'h0000_0000, 10'h000, 5'd1,  1'b0,
          '{blir_pkg::ST_OK, 32'h0, 9'd0}},
        '{blir_pkg::ACT_REMOVE, 32'h0000_0000, 10'h00E, 5'd1,  1'b0,
          '{blir_pkg::ST_OK, 32'h0, 9'd0}},
        '{blir_pkg::ACT_INSERT, 32'h8000_0001, 10'h000, 5'd1,  1'b0,
          '{blir_pkg::ST_OK, 32'h0, 9'd0}},
        '{blir_pkg::ACT_INSERT, 32'h7FFF_FFFE, 10'h00C, 5'd1,  1'b0,
          '{blir_pkg::ST_OK, 32'h0, 9'd0}},
        '{blir_pkg::ACT_READ,   32'h0000_0000, 10'h00C, 5'd1,  1'b0,
          '{blir_pkg::ST_OK, 32'h0, 9'd0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic sink_ready = 1'b0;

    blir_req_if req_if ();
    blir_rsp_if rsp_if ();

    assign rsp_if.ready = sink_ready;

    bounded_list_insert_remove dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #1 i_clk = ~i_clk;

    blir_pkg::t_word  shadow_words [blir_pkg::CAPACITY];
    blir_pkg::t_count shadow_count;
    t_list_rsp        pending_rsps [$];
    int               mismatches   = 0;
    int               quiet_cycles = 0;
    bit               calm         = 1'b0;
    bit               growing      = 1'b1;

    // Applies one request to the shadow list and returns the response it owes.
    function automatic t_list_rsp list_apply(input blir_pkg::t_action act,
                                             input blir_pkg::t_word value,
                                             input logic signed [9:0] pos);
        t_list_rsp res;
        int        idx;
        int        i;
        bit        live;
        idx  = pos;
        live = (idx >= 0) && (idx < int'(shadow_count));
        res.status     = blir_pkg::ST_OK;
        res.read_value = '0;
        case (act)
            blir_pkg::ACT_APPEND: begin
                if (shadow_count < blir_pkg::CAPACITY) begin
                    shadow_words[shadow_count] = value;
                    shadow_count++;
                end else begin
                    res.status = blir_pkg::ST_FULL;
                end
            end
            blir_pkg::ACT_INSERT: begin
                // The position check wins over the full check.
                if (!live) begin
                    res.status = blir_pkg::ST_BAD_INDEX;
                end else if (shadow_count >= blir_pkg::CAPACITY) begin
                    res.status = blir_pkg::ST_FULL;
                end else begin
                    for (i = int'(shadow_count); i > idx; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[idx] = value;
                    shadow_count++;
                end
            end
            blir_pkg::ACT_REMOVE: begin
                if (!live) begin
                    res.status = blir_pkg::ST_BAD_INDEX;
                end else begin
                    for (i = idx; i + 1 < int'(shadow_count); i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                end
            end
            default: begin
                if (!live)
                    res.status = blir_pkg::ST_BAD_INDEX;
                else
                    res.read_value = shadow_words[idx];
            end
        endcase
        res.entry_count = shadow_count;
        return res;
    endfunction

    function automatic logic [9:0] pick_position();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75 && shadow_count != 0)
            return 10'($urandom_range(int'(shadow_count) - 1));
        if (roll < 84)
            return 10'(shadow_count);
        if (roll < 92)
            return 10'($urandom_range(1023, 512));
        return 10'($urandom);
    endfunction

    function automatic blir_pkg::t_word pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        if (roll < 25)
            return blir_pkg::t_word'(1) << $urandom_range(blir_pkg::DATA_WIDTH - 1);
        return blir_pkg::t_word'($urandom);
    endfunction

    task automatic flag_error(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input blir_pkg::t_action act, input blir_pkg::t_word value,
                                input logic [9:0] pos, input bit typed,
                                input t_list_rsp typed_rsp);
        t_list_rsp predicted;
        if (!calm) begin
            while ($urandom_range(99) < 36) begin
                req_if.valid      <= 1'b0;
                req_if.item_value <= $urandom;
                @(negedge i_clk);
            end
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.item_value <= value;
        req_if.position   <= pos;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        predicted = list_apply(act, value, pos);
        pending_rsps.push_back(typed ? typed_rsp : predicted);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        sink_ready <= calm || ($urandom_range(99) >= 36);
    end

    always @(posedge i_clk) begin
        t_list_rsp want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
            if (pending_rsps.size() == 0) begin
                flag_error("unexpected response count", '0, 32'(rsp_if.entry_count));
            end else begin
                want = pending_rsps.pop_front();
                if (rsp_if.status !== want.status)
                    flag_error("status", 32'(want.status), 32'(rsp_if.status));
                if (rsp_if.read_value !== want.read_value)
                    flag_error("read_value", 32'(want.read_value), rsp_if.read_value);
                if (rsp_if.entry_count !== want.entry_count)
                    flag_error("entry_count", 32'(want.entry_count),
                               32'(rsp_if.entry_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bounded_list_insert_remove test failed");
            $finish;
        end
    end

    initial begin
        blir_pkg::t_action act;
        int                roll;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.action     <= blir_pkg::ACT_APPEND;
        req_if.item_value <= '0;
        req_if.position   <= '0;
        shadow_count = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            repeat (STEPS[r].repeats)
                send_request(STEPS[r].action, STEPS[r].value, STEPS[r].position,
                             STEPS[r].typed, STEPS[r].rsp);
        end

        // Drift between growing and shrinking phases so the list keeps
        // passing through both the empty and the full state.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 350) && (n < 550);
            if (shadow_count == blir_pkg::CAPACITY && $urandom_range(3) == 0)
                growing = 1'b0;
            else if (shadow_count == 0)
                growing = 1'b1;
            else if ($urandom_range(49) == 0)
                growing = !growing;
            roll = $urandom_range(99);
            if (growing)
                act = (roll < 40) ? blir_pkg::ACT_APPEND :
                      (roll < 65) ? blir_pkg::ACT_INSERT :
                      (roll < 80) ? blir_pkg::ACT_REMOVE : blir_pkg::ACT_READ;
            else
                act = (roll < 10) ? blir_pkg::ACT_APPEND :
                      (roll < 25) ? blir_pkg::ACT_INSERT :
                      (roll < 65) ? blir_pkg::ACT_REMOVE : blir_pkg::ACT_READ;
            send_request(act, pick_value(), pick_position(), 1'b0, '0);
        end
        calm = 1'b0;
        req_if.valid <= 1'b0;

        while (pending_rsps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("bounded_list_insert_remove test passed");
        else
            $display("bounded_list_insert_remove test failed");
        $finish;
    end

endmodule
